// ===== rtl/wph_pkg.sv =====
// Shared types and constants for the WAV PCM header parser.
// No dependencies; used by wph_step and wav_pcm_header_parser_top.
package wph_pkg;

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_SCAN   = 5'b00010,
		PH_SIZE   = 5'b00100,
		PH_DATA   = 5'b01000,
		PH_DRAIN  = 5'b10000
	} phase_t;

	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_BAD    = 2'd2;

	// tags as they sit in the little-endian assembler
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_LIST = 32'h5453_494c;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [31:0] FMT_SIZE = 32'd16;

	localparam logic [23:0] WIN_DAT  = 24'h646174;
	localparam logic [7:0]  CHAR_A   = 8'h61;

	localparam logic [15:0] FMT_PCM  = 16'd1;
	localparam logic [15:0] CH_MONO  = 16'd1;
	localparam logic [15:0] CH_STEREO = 16'd2;

	// header byte offsets at which a field completes
	localparam logic [5:0] OFS_RIFF  = 6'd3;
	localparam logic [5:0] OFS_WAVE  = 6'd11;
	localparam logic [5:0] OFS_FMT   = 6'd15;
	localparam logic [5:0] OFS_FSIZE = 6'd19;
	localparam logic [5:0] OFS_AFMT  = 6'd21;
	localparam logic [5:0] OFS_CHAN  = 6'd23;
	localparam logic [5:0] OFS_RATE  = 6'd27;
	localparam logic [5:0] OFS_BITS  = 6'd35;
	localparam logic [5:0] OFS_CHUNK = 6'd39;
	localparam logic [5:0] OFS_SIZE_LAST = 6'd3;

	typedef struct packed {
		phase_t       phase;
		logic [5:0]   offset;
		logic [31:0]  asm_word;
		logic [23:0]  window;
		logic [1:0]   chan;
		logic [31:0]  rate;
		logic [15:0]  bits;
		logic [31:0]  left;
	} state_t;

	typedef struct packed {
		logic [1:0]   kind;
		logic [7:0]   payload_byte;
		logic [1:0]   channels;
		logic [31:0]  rate_hz;
		logic [15:0]  sample_bits;
		logic [31:0]  payload_size;
		logic         final_res;
	} result_t;

	localparam state_t STATE_RESET = '{
		phase:    PH_HEADER,
		offset:   6'd0,
		asm_word: 32'd0,
		window:   24'd0,
		chan:     2'd0,
		rate:     32'd0,
		bits:     16'd0,
		left:     32'd0
	};

endpackage

// ===== rtl/wph_step.sv =====
// Next-state and result logic for one byte of the WAV parser.
// Depends on wph_pkg.
module wph_step (
	input  wph_pkg::state_t  st,
	input  logic [7:0]       byte_value,
	input  logic             end_of_file,
	output wph_pkg::state_t  nxt,
	output logic             res_valid,
	output wph_pkg::result_t res
);

	logic [31:0] asm_new;
	logic [15:0] asm_hi;
	logic [31:0] left_m1;
	logic        bad;

	assign asm_new = {byte_value, st.asm_word[31:8]};
	assign asm_hi  = asm_new[31:16];
	assign left_m1 = st.left - 32'd1;

	always_comb begin
		nxt       = st;
		res       = '0;
		res_valid = 1'b0;
		bad       = 1'b0;
		unique case (st.phase)
			wph_pkg::PH_HEADER: begin
				nxt.asm_word = asm_new;
				nxt.offset   = st.offset + 6'd1;
				if (end_of_file) begin
					bad = 1'b1;
				end else begin
					unique case (st.offset)
						wph_pkg::OFS_RIFF:  bad = (asm_new != wph_pkg::TAG_RIFF);
						wph_pkg::OFS_WAVE:  bad = (asm_new != wph_pkg::TAG_WAVE);
						wph_pkg::OFS_FMT:   bad = (asm_new != wph_pkg::TAG_FMT);
						wph_pkg::OFS_FSIZE: bad = (asm_new != wph_pkg::FMT_SIZE);
						wph_pkg::OFS_AFMT:  bad = (asm_hi != wph_pkg::FMT_PCM);
						wph_pkg::OFS_CHAN: begin
							bad = (asm_hi != wph_pkg::CH_MONO) &&
							      (asm_hi != wph_pkg::CH_STEREO);
							nxt.chan = asm_hi[1:0];
						end
						wph_pkg::OFS_RATE:  nxt.rate = asm_new;
						wph_pkg::OFS_BITS:  nxt.bits = asm_hi;
						wph_pkg::OFS_CHUNK: begin
							if (asm_new == wph_pkg::TAG_DATA) begin
								nxt.phase    = wph_pkg::PH_SIZE;
								nxt.offset   = 6'd0;
								nxt.asm_word = 32'd0;
							end else if (asm_new == wph_pkg::TAG_LIST) begin
								nxt.phase  = wph_pkg::PH_SCAN;
								nxt.offset = st.offset;
								nxt.window = 24'd0;
							end else begin
								bad = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			wph_pkg::PH_SCAN: begin
				if (end_of_file) begin
					bad = 1'b1;
				end else if (st.window == wph_pkg::WIN_DAT && byte_value == wph_pkg::CHAR_A) begin
					nxt.phase    = wph_pkg::PH_SIZE;
					nxt.offset   = 6'd0;
					nxt.asm_word = 32'd0;
					nxt.window   = 24'd0;
				end else begin
					nxt.window = {st.window[15:0], byte_value};
				end
			end
			wph_pkg::PH_SIZE: begin
				nxt.asm_word = asm_new;
				if (st.offset < wph_pkg::OFS_SIZE_LAST) begin
					nxt.offset = st.offset + 6'd1;
					bad        = end_of_file;
				end else if (end_of_file && asm_new != 32'd0) begin
					bad = 1'b1;
				end else begin
					nxt.left         = asm_new;
					res_valid        = 1'b1;
					res.kind         = wph_pkg::KIND_HEADER;
					res.channels     = st.chan;
					res.rate_hz      = st.rate;
					res.sample_bits  = st.bits;
					res.payload_size = asm_new;
					res.final_res    = (asm_new == 32'd0);
					if (asm_new != 32'd0) begin
						nxt.phase = wph_pkg::PH_DATA;
					end else if (end_of_file) begin
						nxt = wph_pkg::STATE_RESET;
					end else begin
						nxt.phase = wph_pkg::PH_DRAIN;
					end
				end
			end
			wph_pkg::PH_DATA: begin
				nxt.left = left_m1;
				if (end_of_file && left_m1 != 32'd0) begin
					bad = 1'b1;
				end else begin
					res_valid        = 1'b1;
					res.kind         = wph_pkg::KIND_DATA;
					res.payload_byte = byte_value;
					res.final_res    = (left_m1 == 32'd0);
					if (left_m1 == 32'd0) begin
						if (end_of_file) begin
							nxt = wph_pkg::STATE_RESET;
						end else begin
							nxt.phase = wph_pkg::PH_DRAIN;
						end
					end
				end
			end
			wph_pkg::PH_DRAIN: begin
				if (end_of_file) begin
					nxt = wph_pkg::STATE_RESET;
				end
			end
			default: nxt = wph_pkg::STATE_RESET;
		endcase

		// a failed check or early end of file overrides everything else
		if (bad) begin
			res           = '0;
			res.kind      = wph_pkg::KIND_BAD;
			res.final_res = 1'b1;
			res_valid     = 1'b1;
			if (end_of_file) begin
				nxt = wph_pkg::STATE_RESET;
			end else begin
				nxt.phase = wph_pkg::PH_DRAIN;
			end
		end
	end

endmodule

// ===== rtl/wav_pcm_header_parser_top.sv =====
// WAV PCM header parser, top level: parse state and output register.
// A result is held in the output register from the cycle after its input beat is accepted.
// Throughput: one byte per cycle; in_ready drops only while a result waits unread.
// Each byte goes through wph_step in the cycle it is accepted.
// Reset (arst_n low, asynchronous): header phase, all fields zero, output empty.
// Depends on wph_pkg and wph_step.
module wav_pcm_header_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	// input beats: one file byte each
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        end_of_file,
	// result beats
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [1:0]  channels,
	output logic [31:0] rate_hz,
	output logic [15:0] sample_bits,
	output logic [31:0] payload_size,
	output logic        final_res
);

	wph_pkg::state_t  state_q;
	wph_pkg::state_t  state_nxt;
	wph_pkg::result_t res_nxt;
	wph_pkg::result_t res_q;
	logic             res_vld_nxt;
	logic             out_valid_q;
	logic             in_fire;

	// The output register frees up in the same cycle its beat is taken, so
	// the input keeps streaming as long as the consumer keeps up.
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	wph_step u_step (
		.st          (state_q),
		.byte_value  (byte_value),
		.end_of_file (end_of_file),
		.nxt         (state_nxt),
		.res_valid   (res_vld_nxt),
		.res         (res_nxt)
	);

	// parse state advances only on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wph_pkg::STATE_RESET;
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= res_vld_nxt;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire && res_vld_nxt) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = res_q.kind;
	assign payload_byte = res_q.payload_byte;
	assign channels     = res_q.channels;
	assign rate_hz      = res_q.rate_hz;
	assign sample_bits  = res_q.sample_bits;
	assign payload_size = res_q.payload_size;
	assign final_res    = res_q.final_res;

endmodule
